// ===== design/short_long_press_mode_selector_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the press mode selector
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SHORT_LONG_PRESS_MODE_SELECTOR_ASSERT_SVH
`define SHORT_LONG_PRESS_MODE_SELECTOR_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define SLPMS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slpms: same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define SLPMS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slpms: next-cycle check failed");

`endif

// ===== design/slpms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpms_pkg
// Types, codes and helpers for the short/long press mode selector.
// ----------------------------------------------------------------------------
package slpms_pkg;

  // Width of the timestamp arithmetic; durations wrap modulo 2**TimeWidth.
  localparam int unsigned TimeWidth = 32;

  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;

  localparam logic [CfgWidth-1:0] DebounceReset  = CfgWidth'(50);
  localparam logic [CfgWidth-1:0] LongPressReset = CfgWidth'(1000);

  // Register index, taken from paddr[2].
  localparam logic RegDebounce  = 1'b0;
  localparam logic RegLongPress = 1'b1;

  typedef enum logic [1:0] {
    EvNone   = 2'd0,
    EvSwitch = 2'd1,
    EvStart  = 2'd2,
    EvStop   = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    ColourWhite = 2'd0,
    ColourRed   = 2'd1,
    ColourGreen = 2'd2,
    ColourBlue  = 2'd3
  } colour_e;

  // Active-low drive, bit 0 red, bit 1 green, bit 2 blue.
  localparam logic [2:0] DriveOff = 3'b111;

  typedef struct packed {
    logic        button_level;
    logic [31:0] time_ms;
  } in_t;

  typedef struct packed {
    logic       led_red_n;
    logic       led_green_n;
    logic       led_blue_n;
    logic [1:0] event_code;
    logic [1:0] colour_now;
    logic       white_active;
  } out_t;

  function automatic logic [2:0] drive_for(logic [1:0] colour);
    logic [2:0] drive;
    case (colour)
      ColourWhite: drive = 3'b000;
      ColourRed:   drive = 3'b110;
      ColourGreen: drive = 3'b101;
      default:     drive = 3'b011;
    endcase
    return drive;
  endfunction

  // Cycle red -> green -> blue -> red.
  function automatic logic [1:0] next_colour(logic [1:0] colour);
    logic [1:0] nxt;
    case (colour)
      ColourWhite: nxt = ColourRed;
      ColourRed:   nxt = ColourGreen;
      ColourGreen: nxt = ColourBlue;
      default:     nxt = ColourRed;
    endcase
    return nxt;
  endfunction

endpackage

// ===== design/short_long_press_mode_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// short_long_press_mode_selector
// Classifies push-button presses as short or long and drives the RGB mode.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_data_i) carries one beat
//   per button sample: the sampled active-low level and a wrapping millisecond
//   timestamp. Each input beat produces exactly one output beat on
//   (out_valid_o / out_ready_i / out_data_o) holding the active-low RGB drive,
//   the event code, the selected colour and the white-mode flag.
//   The output is registered: the result of an accepted beat is shown from
//   the next cycle. Throughput is one beat per cycle while the receiver takes
//   each output beat; the edge detect, one subtraction and two compares sit
//   between the state and the output register.
//   The input is taken whenever the output register is empty or is being
//   drained in the same cycle. When the receiver stalls, the output beat holds
//   and the input side stalls with it after one beat.
//   Reset clears the output register, releases the button, disarms the press
//   detector, selects red, leaves white mode and turns all LEDs off. The APB
//   port holds debounce_ms at 0x0 and long_press_ms at 0x4 (reset 50, 1000);
//   write them only while no beat is in flight.
// ----------------------------------------------------------------------------
`include "short_long_press_mode_selector_assert.svh"

module short_long_press_mode_selector (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Sample channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  slpms_pkg::in_t                     in_data_i,
  // Result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output slpms_pkg::out_t                    out_data_o,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [slpms_pkg::AddrWidth-1:0]    paddr,
  input  logic [slpms_pkg::DataWidth-1:0]    pwdata,
  output logic [slpms_pkg::DataWidth-1:0]    prdata,
  output logic                               pready
);

  localparam int unsigned TW = slpms_pkg::TimeWidth;
  localparam int unsigned CW = slpms_pkg::CfgWidth;

  // Configuration registers
  logic [CW-1:0] debounce_q;
  logic [CW-1:0] long_press_q;
  logic          cfg_write;

  // Press state
  logic          prev_level_q, prev_level_d;
  logic          armed_q, armed_d;
  logic [TW-1:0] press_start_q, press_start_d;
  logic          white_q, white_d;
  logic [1:0]    colour_q, colour_d;
  logic [1:0]    saved_colour_q, saved_colour_d;
  logic [2:0]    led_q, led_d;

  // Output register
  logic             out_valid_q;
  slpms_pkg::out_t  out_data_q, out_data_d;

  logic                      in_fire;
  logic [TW-1:0]             now;
  logic [TW-1:0]             duration;
  logic                      fall_edge;
  logic                      rise_edge;
  slpms_pkg::event_e         event_d;

  // --------------------------------------------------------------------------
  // Configuration port: zero wait states, register picked by paddr[2].
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= slpms_pkg::DebounceReset;
      long_press_q <= slpms_pkg::LongPressReset;
    end else if (cfg_write) begin
      if (paddr[2] == slpms_pkg::RegDebounce) begin
        debounce_q <= pwdata[CW-1:0];
      end else begin
        long_press_q <= pwdata[CW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == slpms_pkg::RegDebounce) begin
      prdata = slpms_pkg::DataWidth'(debounce_q);
    end else begin
      prdata = slpms_pkg::DataWidth'(long_press_q);
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: take a new beat when the output register is free or draining.
  // --------------------------------------------------------------------------
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  // --------------------------------------------------------------------------
  // Press classification for the incoming sample.
  // --------------------------------------------------------------------------
  assign now       = TW'(in_data_i.time_ms);
  assign fall_edge = ~in_data_i.button_level & prev_level_q;
  assign rise_edge = in_data_i.button_level & ~prev_level_q;
  // Wrapping duration; only meaningful on a rising edge while armed.
  assign duration  = now - press_start_q;

  always_comb begin
    prev_level_d   = in_data_i.button_level;
    armed_d        = armed_q;
    press_start_d  = press_start_q;
    white_d        = white_q;
    colour_d       = colour_q;
    saved_colour_d = saved_colour_q;
    led_d          = led_q;
    event_d        = slpms_pkg::EvNone;

    // Arm and record the press start on a press.
    if (fall_edge) begin
      armed_d       = 1'b1;
      press_start_d = now;
    end

    // Measure on release; presses at or below the debounce limit are noise.
    if (rise_edge && armed_q) begin
      armed_d = 1'b0;
      if (duration > TW'(debounce_q)) begin
        if (duration < TW'(long_press_q)) begin
          if (white_q) begin
            // Short press in white mode: restore the saved colour.
            led_d   = slpms_pkg::drive_for(saved_colour_q);
            white_d = 1'b0;
            event_d = slpms_pkg::EvStop;
          end else begin
            // Short press: advance to the next colour.
            colour_d = slpms_pkg::next_colour(colour_q);
            led_d    = slpms_pkg::drive_for(slpms_pkg::next_colour(colour_q));
            event_d  = slpms_pkg::EvSwitch;
          end
        end else if (!white_q) begin
          // Long press: save the colour and go white.
          saved_colour_d = colour_q;
          led_d          = slpms_pkg::drive_for(slpms_pkg::ColourWhite);
          white_d        = 1'b1;
          event_d        = slpms_pkg::EvStart;
        end
      end
    end

    out_data_d.led_red_n    = led_d[0];
    out_data_d.led_green_n  = led_d[1];
    out_data_d.led_blue_n   = led_d[2];
    out_data_d.event_code   = event_d;
    out_data_d.colour_now   = colour_d;
    out_data_d.white_active = white_d;
  end

  // --------------------------------------------------------------------------
  // State and output registers; state advances only on an accepted beat.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q   <= 1'b1;
      armed_q        <= 1'b0;
      press_start_q  <= '0;
      white_q        <= 1'b0;
      colour_q       <= slpms_pkg::ColourRed;
      saved_colour_q <= slpms_pkg::ColourRed;
      led_q          <= slpms_pkg::DriveOff;
      out_valid_q    <= 1'b0;
    end else begin
      if (in_fire) begin
        prev_level_q   <= prev_level_d;
        armed_q        <= armed_d;
        press_start_q  <= press_start_d;
        white_q        <= white_d;
        colour_q       <= colour_d;
        saved_colour_q <= saved_colour_d;
        led_q          <= led_d;
        out_valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        // Drop the beat once the receiver has taken it.
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload register needs no reset; hold it while stalled.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // White mode always drives all three LEDs on.
  `SLPMS_ASSERT_NOW(a_white_drive, clk_i, rst_ni, white_q, led_q == 3'b000)
  // The selected colour is never the white code.
  `SLPMS_ASSERT_NOW(a_colour_valid, clk_i, rst_ni, 1'b1,
                    colour_q != slpms_pkg::ColourWhite)
  // A start-recording beat leaves the block in white mode with the beat shown.
  `SLPMS_ASSERT_NEXT(a_start_enters_white, clk_i, rst_ni,
                     in_fire && (event_d == slpms_pkg::EvStart),
                     white_q && out_valid_o && out_data_o.white_active)

endmodule
